FILE: src/armw_pkg.sv
// ----------------------------------------------------------------------------
// armw_pkg: shared definitions for the atomic read-modify-write unit
// Store geometry, action codes, controller states and the command and status
// groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package armw_pkg;

	// Word store geometry. The request index is 10 bits wide, so the store
	// holds at most 1024 words.
	localparam int WORD_COUNT = 1024;
	localparam int IDX_W      = $clog2(WORD_COUNT);
	localparam int WORD_W     = 32;
	localparam int PAIR_W     = 2 * WORD_W;

	// Action codes carried in the request.
	localparam logic [2:0] ACT_LOAD = 3'd0;
	localparam logic [2:0] ACT_SWAP = 3'd1;
	localparam logic [2:0] ACT_ADD  = 3'd2;
	localparam logic [2:0] ACT_AND  = 3'd3;
	localparam logic [2:0] ACT_OR   = 3'd4;
	localparam logic [2:0] ACT_CAS  = 3'd5;

	// Controller states.
	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ_HI,
		ST_READ_LO,
		ST_CAPTURE,
		ST_EXEC,
		ST_WRITE_HI,
		ST_WRITE_LO,
		ST_RESPOND
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clear_we;   // write zero at the clearing counter
		logic load_req;   // latch the incoming request
		logic read_lo;    // read at the low word index instead of the high one
		logic cap_hi;     // capture read data as the high (or only) word
		logic cap_lo;     // capture read data as the low word
		logic exec;       // compute and register the new value
		logic wr_hi;      // write the high (or only) word
		logic wr_lo;      // write the low word
		logic load_out;   // move the result into the output register
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clear_done; // clearing counter is at the last word
		logic wide;       // latched request is a word pair
		logic out_full;   // output register holds a result not yet taken
	} sts_t;

endpackage

FILE: src/armw_datapath.sv
// ----------------------------------------------------------------------------
// armw_datapath: word store, request registers and operation logic
// Holds the word store (one read port, one write port), the latched request,
// the captured old value, the computed new value and the output register.
// ----------------------------------------------------------------------------
module armw_datapath (
	input  logic                  clk,
	input  logic                  arst_n,
	input  armw_pkg::cmd_t        cmd,
	output armw_pkg::sts_t        sts,
	input  logic [3:0]            s_tuser,  // action[2:0], is_wide[3]
	input  logic [143:0]          s_tdata,  // word_index, operand, compare_value
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [63:0]           m_tdata,  // old_value
	output logic [0:0]            m_tuser   // success
);

	localparam logic [armw_pkg::IDX_W-1:0] LAST_IDX =
		armw_pkg::IDX_W'(armw_pkg::WORD_COUNT - 1);

	// Word store.
	logic [armw_pkg::WORD_W-1:0] mem [armw_pkg::WORD_COUNT];
	logic [armw_pkg::WORD_W-1:0] rdata_q;
	logic [armw_pkg::IDX_W-1:0]  raddr;
	logic [armw_pkg::IDX_W-1:0]  waddr;
	logic [armw_pkg::WORD_W-1:0] wdata;
	logic                        we;

	// Request and working registers.
	logic [2:0]                  action_q;
	logic                        wide_q;
	logic [armw_pkg::IDX_W-1:0]  hi_idx_q;
	logic [armw_pkg::IDX_W-1:0]  lo_idx;
	logic [armw_pkg::PAIR_W-1:0] opnd_q;
	logic [armw_pkg::PAIR_W-1:0] cmp_q;
	logic [armw_pkg::WORD_W-1:0] old_hi_q;
	logic [armw_pkg::WORD_W-1:0] old_lo_q;
	logic [armw_pkg::PAIR_W-1:0] new_q;
	logic [armw_pkg::PAIR_W-1:0] old_q;
	logic                        ok_q;
	logic [armw_pkg::IDX_W-1:0]  clr_cnt_q;

	// Output register.
	logic                        out_valid_q;
	logic [armw_pkg::PAIR_W-1:0] out_data_q;
	logic                        out_ok_q;

	// Operation logic.
	logic [armw_pkg::PAIR_W-1:0] old_val;
	logic [armw_pkg::PAIR_W-1:0] mask;
	logic [armw_pkg::PAIR_W-1:0] opnd_m;
	logic [armw_pkg::PAIR_W-1:0] cmp_m;
	logic [armw_pkg::PAIR_W-1:0] new_val;
	logic                        ok_val;

	// The low word of a pair sits at the next index and wraps to zero.
	assign lo_idx = (hi_idx_q == LAST_IDX) ? '0 : hi_idx_q + 1'b1;

	// Store port selection.
	always_comb begin
		raddr = cmd.read_lo ? lo_idx : hi_idx_q;
		we    = cmd.clear_we | cmd.wr_hi | cmd.wr_lo;
		if (cmd.clear_we) begin
			waddr = clr_cnt_q;
			wdata = '0;
		end else if (cmd.wr_lo) begin
			waddr = lo_idx;
			wdata = new_q[armw_pkg::WORD_W-1:0];
		end else begin
			waddr = hi_idx_q;
			wdata = wide_q ? new_q[armw_pkg::PAIR_W-1:armw_pkg::WORD_W]
			               : new_q[armw_pkg::WORD_W-1:0];
		end
	end

	// Store with registered read data.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	// Clearing counter used after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clear_we) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	// Latch the request fields. The index keeps the bits the store needs.
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			action_q <= s_tuser[2:0];
			wide_q   <= s_tuser[3];
			hi_idx_q <= s_tdata[armw_pkg::IDX_W-1:0];
			opnd_q   <= s_tdata[73:10];
			cmp_q    <= s_tdata[137:74];
		end
		if (cmd.cap_hi) begin
			old_hi_q <= rdata_q;
		end
		if (cmd.cap_lo) begin
			old_lo_q <= rdata_q;
		end
		if (cmd.exec) begin
			new_q <= new_val;
			old_q <= old_val;
			ok_q  <= ok_val;
		end
	end

	// New value for the action; narrow requests work in the low 32 bits.
	always_comb begin
		old_val = wide_q ? {old_hi_q, old_lo_q} : {{armw_pkg::WORD_W{1'b0}}, old_hi_q};
		mask    = wide_q ? {armw_pkg::PAIR_W{1'b1}}
		                 : {{armw_pkg::WORD_W{1'b0}}, {armw_pkg::WORD_W{1'b1}}};
		opnd_m  = opnd_q & mask;
		cmp_m   = cmp_q & mask;
		ok_val  = 1'b1;
		case (action_q)
			armw_pkg::ACT_SWAP: new_val = opnd_m;
			armw_pkg::ACT_ADD:  new_val = (old_val + opnd_q) & mask;
			armw_pkg::ACT_AND:  new_val = old_val & opnd_m;
			armw_pkg::ACT_OR:   new_val = old_val | opnd_m;
			armw_pkg::ACT_CAS: begin
				if (cmp_m == old_val) begin
					new_val = opnd_m;
				end else begin
					new_val = old_val;
					ok_val  = 1'b0;
				end
			end
			default:            new_val = old_val;
		endcase
	end

	// Output register; it holds the result until the consumer takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_data_q <= old_q;
			out_ok_q   <= ok_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_ok_q;

	// Status toward the controller.
	assign sts.clear_done = (clr_cnt_q == LAST_IDX);
	assign sts.wide       = wide_q;
	assign sts.out_full   = out_valid_q & ~m_tready;

endmodule

FILE: src/armw_ctrl.sv
// ----------------------------------------------------------------------------
// armw_ctrl: sequencer for the atomic read-modify-write unit
// Clears the store after reset, then steps each request through read,
// compute, write back and respond.
// ----------------------------------------------------------------------------
module armw_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  armw_pkg::sts_t  sts,
	output armw_pkg::cmd_t  cmd
);

	armw_pkg::state_t state_q;
	armw_pkg::state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= armw_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			armw_pkg::ST_CLEAR: begin
				if (sts.clear_done) begin
					state_d = armw_pkg::ST_IDLE;
				end
			end
			armw_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					state_d = armw_pkg::ST_READ_HI;
				end
			end
			armw_pkg::ST_READ_HI:  state_d = armw_pkg::ST_READ_LO;
			armw_pkg::ST_READ_LO:  state_d = armw_pkg::ST_CAPTURE;
			armw_pkg::ST_CAPTURE:  state_d = armw_pkg::ST_EXEC;
			armw_pkg::ST_EXEC:     state_d = armw_pkg::ST_WRITE_HI;
			armw_pkg::ST_WRITE_HI: begin
				state_d = sts.wide ? armw_pkg::ST_WRITE_LO : armw_pkg::ST_RESPOND;
			end
			armw_pkg::ST_WRITE_LO: state_d = armw_pkg::ST_RESPOND;
			armw_pkg::ST_RESPOND: begin
				if (!sts.out_full) begin
					state_d = armw_pkg::ST_IDLE;
				end
			end
			default:               state_d = armw_pkg::ST_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			armw_pkg::ST_CLEAR:    cmd.clear_we = 1'b1;
			armw_pkg::ST_IDLE: begin
				s_tready     = 1'b1;
				cmd.load_req = s_tvalid;
			end
			armw_pkg::ST_READ_HI:  cmd.read_lo = 1'b0;
			armw_pkg::ST_READ_LO: begin
				cmd.read_lo = 1'b1;
				cmd.cap_hi  = 1'b1;
			end
			armw_pkg::ST_CAPTURE:  cmd.cap_lo = 1'b1;
			armw_pkg::ST_EXEC:     cmd.exec = 1'b1;
			armw_pkg::ST_WRITE_HI: cmd.wr_hi = 1'b1;
			armw_pkg::ST_WRITE_LO: cmd.wr_lo = 1'b1;
			armw_pkg::ST_RESPOND:  cmd.load_out = ~sts.out_full;
			default:               cmd = '0;
		endcase
	end

endmodule

FILE: src/atomic_read_modify_write_unit_top.sv
// Requests: a new request is taken only after the previous result has entered the output
// register; the store has one read port and one write port, and the controller issues each
// read and each write back in a state of its own.
// Reset: after arst_n is released a clearing pass writes zero to all 1024 words,
// one per cycle, and no request is taken until it ends.
// ----------------------------------------------------------------------------
// atomic_read_modify_write_unit_top: atomic memory operation unit
// Applies one indivisible read-modify-write to a 32-bit word or a 64-bit
// big-endian word pair per request and returns the old value and a flag.
// ----------------------------------------------------------------------------
module atomic_read_modify_write_unit_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [143:0] s_tdata,  // word_index[9:0], operand[73:10], compare_value[137:74]
	input  logic [3:0]   s_tuser,  // action[2:0], is_wide[3]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [63:0]  m_tdata,  // old_value[63:0]
	output logic [0:0]   m_tuser   // success[0]
);

	armw_pkg::cmd_t cmd;
	armw_pkg::sts_t sts;

	// Controller.
	armw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Datapath.
	armw_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

FILE: bench/atomic_read_modify_write_unit_top_test.sv
// ----------------------------------------------------------------------------
// atomic_read_modify_write_unit_top_test: self-checking bench for the atomic unit
// Sends a short table of directed requests and then a long random stream. The
// random stream is weighted toward a few hot words, word pairs that wrap, and
// compare-and-swap requests that match. Each taken request goes through a
// local copy of the word store to predict the old value and the success flag.
// Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module atomic_read_modify_write_unit_top_test;

	timeunit 1ns;
	timeprecision 1ps;

	// Action codes with no operation of their own; the unit treats them as a load.
	localparam logic [2:0] ACT_RSVD6 = 3'd6;
	localparam logic [2:0] ACT_RSVD7 = 3'd7;

	localparam int RANDOM_REQUESTS = 650;

	typedef logic [armw_pkg::IDX_W-1:0] idx_t;

	typedef struct packed {
		logic [2:0]  action;
		logic        is_wide;
		idx_t        word_index;
		logic [63:0] operand;
		logic [63:0] compare_value;
	} amo_req_t;

	typedef struct packed {
		logic [63:0] old_value;
		logic        success;
	} amo_result_t;

	typedef struct packed {
		amo_req_t    req;
		logic        typed;   // the expected result is written in the row
		amo_result_t result;
	} directed_row_t;

	logic         clk;
	logic         arst_n   = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [143:0] s_tdata  = '0;   // word_index[9:0], operand[73:10], compare_value[137:74]
	logic [3:0]   s_tuser  = '0;   // action[2:0], is_wide[3]
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [63:0]  m_tdata;         // old_value[63:0]
	logic [0:0]   m_tuser;         // success[0]

	// Copy of the word store as the unit should hold it after every taken request.
	logic [armw_pkg::WORD_W-1:0] mirror_words [armw_pkg::WORD_COUNT];
	amo_result_t       pending_results [$];
	directed_row_t     directed_rows [$];
	int                err_count   = 0;
	bit                quiet_phase = 1'b0;

	atomic_read_modify_write_unit_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Applies one request to the mirror store and returns what the unit should answer.
	function automatic amo_result_t apply_atomic(input amo_req_t r);
		idx_t             hi_idx;
		idx_t             lo_idx;
		logic [63:0]      mask;
		logic [63:0]      prior;
		logic [63:0]      updated;
		amo_result_t      res;
		hi_idx = r.word_index;
		lo_idx = hi_idx + 1'b1;
		mask   = r.is_wide ? {64{1'b1}} : {32'b0, {32{1'b1}}};
		prior  = r.is_wide ? {mirror_words[hi_idx], mirror_words[lo_idx]}
		                   : {32'b0, mirror_words[hi_idx]};
		res.success = 1'b1;
		case (r.action)
			armw_pkg::ACT_SWAP: updated = r.operand & mask;
			armw_pkg::ACT_ADD:  updated = (prior + r.operand) & mask;
			armw_pkg::ACT_AND:  updated = prior & r.operand & mask;
			armw_pkg::ACT_OR:   updated = (prior | r.operand) & mask;
			armw_pkg::ACT_CAS: begin
				if ((r.compare_value & mask) == prior) begin
					updated = r.operand & mask;
				end else begin
					updated     = prior;
					res.success = 1'b0;
				end
			end
			default:  updated = prior;
		endcase
		if (r.is_wide) begin
			mirror_words[hi_idx] = updated[63:32];
			mirror_words[lo_idx] = updated[31:0];
		end else begin
			mirror_words[hi_idx] = updated[31:0];
		end
		res.old_value = prior;
		return res;
	endfunction

	// Idle length: mostly none or short, now and then long.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 40) return 0;
		if (roll < 85) return $urandom_range(1, 3);
		if (roll < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	// Data word with a bias toward the all-zero and all-one extremes.
	function automatic logic [63:0] pick_data();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll == 0) return '0;
		if (roll == 1) return {64{1'b1}};
		return {$urandom(), $urandom()};
	endfunction

	function automatic void add_row(input logic [2:0] action, input logic is_wide,
	                                input int word_index, input logic [63:0] operand,
	                                input logic [63:0] compare_value, input logic typed,
	                                input logic [63:0] old_value, input logic success);
		directed_row_t row;
		row.req.action          = action;
		row.req.is_wide         = is_wide;
		row.req.word_index      = word_index[armw_pkg::IDX_W-1:0];
		row.req.operand         = operand;
		row.req.compare_value   = compare_value;
		row.typed               = typed;
		row.result.old_value    = old_value;
		row.result.success      = success;
		directed_rows.push_back(row);
	endfunction

	// Offers one request after a random gap (none in the quiet phase) and records its expected result once taken.
	task automatic send_request(input amo_req_t r, input logic typed,
	                            input amo_result_t typed_result);
		int          gap;
		amo_result_t predicted;
		gap = quiet_phase ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {6'b0, r.compare_value, r.operand, r.word_index};
		s_tuser  <= {r.is_wide, r.action};
		do @(posedge clk); while (!s_tready);
		predicted = apply_atomic(r);
		pending_results.push_back(typed ? typed_result : predicted);
	endtask

	// Result side: check each taken result and stall at random.
	initial begin : result_check
		int          stall_left;
		amo_result_t want;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				if (pending_results.size() == 0) begin
					$error("result with no request pending: old_value %h success %b",
					       m_tdata, m_tuser[0]);
					err_count++;
				end else begin
					want = pending_results.pop_front();
					if (m_tdata !== want.old_value) begin
						$error("old_value: expected %h, got %h", want.old_value, m_tdata);
						err_count++;
					end
					if (m_tuser[0] !== want.success) begin
						$error("success: expected %b, got %b", want.success, m_tuser[0]);
						err_count++;
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (!quiet_phase && $urandom_range(0, 3) == 0) stall_left = pick_gap();
			end
		end
	end

	// Request side: reset, directed table, random stream, drain.
	initial begin : request_drive
		amo_req_t         r;
		amo_result_t      none;
		idx_t             lo_idx;
		int               roll;
		for (int i = 0; i < armw_pkg::WORD_COUNT; i++) mirror_words[i] = '0;
		none = '0;

		// The store starts cleared, so early results can be written down directly.
		add_row(armw_pkg::ACT_LOAD, 1'b0, 0,    64'h0, 64'h0, 1'b1, 64'h0, 1'b1);
		add_row(armw_pkg::ACT_LOAD, 1'b1, 1023, 64'h0, 64'h0, 1'b1, 64'h0, 1'b1);
		add_row(armw_pkg::ACT_SWAP, 1'b0, 1023, {64{1'b1}}, 64'h0, 1'b1, 64'h0, 1'b1);
		add_row(armw_pkg::ACT_LOAD, 1'b0, 1023, 64'h0, 64'h0, 1'b1,
		        64'h0000_0000_FFFF_FFFF, 1'b1);
		// Narrow add overflow wraps the word back to zero.
		add_row(armw_pkg::ACT_ADD,  1'b0, 1023, 64'h1, 64'h0, 1'b1,
		        64'h0000_0000_FFFF_FFFF, 1'b1);
		add_row(armw_pkg::ACT_LOAD, 1'b1, 1023, 64'h0, 64'h0, 1'b1, 64'h0, 1'b1);
		// A pair at the last word keeps its low half in word zero.
		add_row(armw_pkg::ACT_SWAP, 1'b1, 1023, 64'h0123_4567_89AB_CDEF, 64'h0,
		        1'b1, 64'h0, 1'b1);
		add_row(armw_pkg::ACT_LOAD, 1'b0, 0,    64'h0, 64'h0, 1'b1,
		        64'h0000_0000_89AB_CDEF, 1'b1);
		add_row(armw_pkg::ACT_LOAD, 1'b1, 1023, 64'h0, 64'h0, 1'b1,
		        64'h0123_4567_89AB_CDEF, 1'b1);
		add_row(armw_pkg::ACT_ADD,  1'b1, 1023, {64{1'b1}}, 64'h0, 1'b0, 64'h0, 1'b0);
		add_row(armw_pkg::ACT_AND,  1'b0, 0,    64'hFFFF_FFFF_0000_FFFF, 64'h0,
		        1'b0, 64'h0, 1'b0);
		add_row(armw_pkg::ACT_OR,   1'b1, 512,  64'h8000_0001_0000_0003, 64'h0,
		        1'b1, 64'h0, 1'b1);
		// Compare-and-swap: a narrow miss, a narrow hit with junk in the upper half, a wide hit, a wide miss.
		add_row(armw_pkg::ACT_CAS,  1'b0, 512,  64'h5, 64'h0, 1'b1,
		        64'h0000_0000_8000_0001, 1'b0);
		add_row(armw_pkg::ACT_CAS,  1'b0, 512,  64'hFFFF_FFFF_0000_0007,
		        64'hFFFF_FFFF_8000_0001, 1'b1, 64'h0000_0000_8000_0001, 1'b1);
		add_row(armw_pkg::ACT_CAS,  1'b1, 512,  64'hFEDC_BA98_7654_3210,
		        64'h0000_0007_0000_0003, 1'b1, 64'h0000_0007_0000_0003, 1'b1);
		add_row(armw_pkg::ACT_CAS,  1'b1, 512,  64'h0, 64'h0000_0007_0000_0003,
		        1'b1, 64'hFEDC_BA98_7654_3210, 1'b0);
		// Unused action codes read and leave the words unchanged.
		add_row(ACT_RSVD6, 1'b0, 512,  {64{1'b1}}, 64'h0, 1'b1, 64'h0000_0000_FEDC_BA98, 1'b1);
		add_row(ACT_RSVD7, 1'b1, 512,  {64{1'b1}}, 64'h0, 1'b1, 64'hFEDC_BA98_7654_3210, 1'b1);
		add_row(armw_pkg::ACT_LOAD, 1'b1, 512,  64'h0, 64'h0, 1'b1,
		        64'hFEDC_BA98_7654_3210, 1'b1);
		add_row(armw_pkg::ACT_AND,  1'b1, 1023, 64'h0, 64'h0, 1'b0, 64'h0, 1'b0);
		add_row(armw_pkg::ACT_OR,   1'b0, 1,    64'hFFFF_FFFF_0000_0000, 64'h0,
		        1'b0, 64'h0, 1'b0);
		add_row(armw_pkg::ACT_CAS,  1'b1, 1023, {64{1'b1}}, 64'h0, 1'b1, 64'h0, 1'b1);
		add_row(armw_pkg::ACT_LOAD, 1'b0, 1,    64'h0, 64'h0, 1'b1, 64'h0, 1'b1);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].result);

		// Random stream: hot words and wrapping pairs, many matching compares.
		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			quiet_phase = ((n / 60) % 3) == 2;
			roll = $urandom_range(0, 9);
			if (roll < 3)
				r.word_index = idx_t'($urandom_range(0, 3));
			else if (roll < 5)
				r.word_index = idx_t'($urandom_range(armw_pkg::WORD_COUNT - 3,
				                                     armw_pkg::WORD_COUNT - 1));
			else if (roll < 6)
				r.word_index = idx_t'($urandom_range(510, 513));
			else
				r.word_index = idx_t'($urandom_range(0, armw_pkg::WORD_COUNT - 1));
			roll = $urandom_range(0, 19);
			if (roll < 6)      r.action = armw_pkg::ACT_CAS;
			else if (roll < 8) r.action = 3'($urandom_range(6, 7));
			else               r.action = 3'($urandom_range(0, 4));
			r.is_wide       = 1'($urandom_range(0, 1));
			r.operand       = pick_data();
			r.compare_value = pick_data();
			if (r.action == armw_pkg::ACT_CAS && $urandom_range(0, 9) < 6) begin
				lo_idx = r.word_index + 1'b1;
				if (r.is_wide)
					r.compare_value = {mirror_words[r.word_index], mirror_words[lo_idx]};
				else
					r.compare_value = {$urandom(), mirror_words[r.word_index]};
			end
			send_request(r, 1'b0, none);
		end
		quiet_phase = 1'b0;
		s_tvalid <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (err_count == 0) begin
			$display("atomic_read_modify_write_unit_top_test: done, clean");
		end else begin
			$display("atomic_read_modify_write_unit_top_test: done, errors");
		end
		$finish;
	end

	// Hang guard, far beyond the slowest legal run including the clearing pass.
	initial begin
		#400_000;
		$display("atomic_read_modify_write_unit_top_test: done, errors");
		$finish;
	end

endmodule
